FILE: rtl/circumcircle_point_test_macros.svh
// Assertion macros shared by the circumcircle test RTL.
`ifndef CIRCUMCIRCLE_POINT_TEST_MACROS_SVH
`define CIRCUMCIRCLE_POINT_TEST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CCT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cct_pkg.sv
// Shared constants for the circumcircle point test.
`default_nettype none

package cct_pkg;

    parameter int COORD_BITS_DEF = 32;

endpackage

`default_nettype wire

FILE: rtl/cct_if.sv
// Valid/ready channel interfaces for query and result transactions.
`default_nettype none

interface cct_query_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by_coord;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;

    modport source (output valid, ax, ay, bx, by_coord, cx, cy, px, py, input ready);
    modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, px, py, output ready);
endinterface

interface cct_result_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [CW-2:0]        radius;
    logic                 inside_res;
    logic                 degenerate;

    modport source (output valid, center_x, center_y, radius, inside_res, degenerate,
                    input ready);
    modport sink   (input valid, center_x, center_y, radius, inside_res, degenerate,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/cct_divider.sv
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
`default_nettype none

module cct_divider
    import cct_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [3*CW+3:0]   num,
    input  wire logic [2*CW+3:0]   den,
    output logic      [CW-1:0]     quo,
    output logic                   ovf
);

    localparam int NW   = 3 * CW + 4;
    localparam int DENW = 2 * CW + 4;

    logic [NW-1:0]   rem_reg [0:CW];
    logic [DENW-1:0] den_reg [0:CW];
    logic            ovf_reg [0:CW];
    logic [CW-1:0]   quo_reg [0:CW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            // quotient does not fit CW bits
            ovf_reg[0] <= (num >= (NW'(den) << CW));
            quo_reg[0] <= '0;
            for (int j = 1; j <= CW; j++)
            begin
                logic [NW-1:0] sub;
                logic          fit;
                sub = NW'(den_reg[j-1]) << (CW - j);
                fit = (rem_reg[j-1] >= sub);
                rem_reg[j] <= fit ? (rem_reg[j-1] - sub) : rem_reg[j-1];
                quo_reg[j] <= quo_reg[j-1] | (CW'(fit) << (CW - j));
                den_reg[j] <= den_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign quo = quo_reg[CW];
    assign ovf = ovf_reg[CW];

endmodule

`default_nettype wire

FILE: rtl/cct_sqrt.sv
// Pipelined floor square root: one root bit per stage, remainder form.
`default_nettype none

module cct_sqrt
    import cct_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [2*CW+2:0]   ra,
    output logic      [CW-2:0]     root
);

    localparam int RW = 2 * CW + 3;
    localparam int NST = CW - 1;

    logic [RW-1:0] rem_reg  [0:NST-1];
    logic [CW-2:0] root_reg [0:NST-1];
    logic [RW-1:0] rem_in   [0:NST-1];
    logic [CW-2:0] root_in  [0:NST-1];

    always_comb
    begin
        rem_in[0]  = ra;
        root_in[0] = '0;
        for (int j = 1; j < NST; j++)
        begin
            rem_in[j]  = rem_reg[j-1];
            root_in[j] = root_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NST; j++)
            begin
                logic [RW-1:0] trial;
                logic          fit;
                // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
                trial = (RW'(root_in[j]) << (NST - j)) | (RW'(1) << (2 * (NST - 1 - j)));
                fit   = (trial <= rem_in[j]);
                rem_reg[j]  <= fit ? (rem_in[j] - trial) : rem_in[j];
                root_reg[j] <= root_in[j] | ((CW-1)'(fit) << (NST - 1 - j));
            end
        end
    end

    assign root = root_reg[NST-1];

endmodule

`default_nettype wire

FILE: rtl/circumcircle_point_test.sv
// Circumcircle point test top level. Each query transaction carries triangle
// vertices A, B, C and a point P in signed fixed point; the block returns the
// circumcenter (each coordinate truncated toward zero and saturated), the floor
// of the circumradius, whether P lies within or on the circle, and a flag for
// collinear vertices (then all other result fields are zero). One transaction is
// accepted per clock while the pipeline is not held; the center divider and the
// radius square root resolve one bit per stage. The whole pipeline holds while a
// finished result waits on the output and the sink is not ready.
`default_nettype none
`include "circumcircle_point_test_macros.svh"

module circumcircle_point_test
    import cct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    cct_query_if.sink      query,
    cct_result_if.source   result
);

    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * CW + 1;
    localparam int SQ2W  = 2 * CW;
    localparam int DETW  = 2 * CW + 3;
    localparam int DENW  = 2 * CW + 4;
    localparam int LPW   = 2 * CW + 2;
    localparam int NPW   = 3 * CW + 2;
    localparam int NW    = 3 * CW + 4;
    localparam int D2W   = 2 * DW;
    localparam int RW    = 2 * DW + 1;

    localparam int ST_SAT = 8 + CW;
    localparam int ST_SUM = 11 + CW;
    localparam int ST_OUT = 11 + 2 * CW;
    localparam int NS     = ST_OUT + 1;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
    } pts_t;

    logic          en;
    logic [NS-1:0] v_reg;

    // pipeline payload
    pts_t                   pts_reg  [0:ST_SAT];
    logic signed [CW-1:0]   s0_x_reg [3];
    logic signed [CW-1:0]   s0_y_reg [3];
    logic signed [DW-1:0]   s0_dy_reg[3];
    logic signed [DW-1:0]   s0_dx_reg[3];
    logic signed [PW-1:0]   s1_detp_reg[3];
    logic signed [SQ2W-1:0] s1_sqx_reg[3];
    logic signed [SQ2W-1:0] s1_sqy_reg[3];
    logic signed [DW-1:0]   s1_dy_reg[3];
    logic signed [DW-1:0]   s1_dx_reg[3];
    logic signed [DETW-1:0] s2_det_reg;
    logic [SQ2W-1:0]        s2_aa_reg[3];
    logic signed [DW-1:0]   s2_dy_reg[3];
    logic signed [DW-1:0]   s2_dx_reg[3];
    logic signed [DENW-1:0] s3_den_reg;
    logic signed [LPW-1:0]  s3_xlo_reg[3];
    logic signed [LPW-1:0]  s3_xhi_reg[3];
    logic signed [LPW-1:0]  s3_ylo_reg[3];
    logic signed [LPW-1:0]  s3_yhi_reg[3];
    logic signed [DENW-1:0] s4_den_reg;
    logic signed [NPW-1:0]  s4_npx_reg[3];
    logic signed [NPW-1:0]  s4_npy_reg[3];
    logic signed [DENW-1:0] s5_den_reg;
    logic signed [NW-1:0]   s5_nx_reg;
    logic signed [NW-1:0]   s5_ny_reg;
    logic [NW-1:0]          s6_nxm_reg;
    logic [NW-1:0]          s6_nym_reg;
    logic [DENW-1:0]        s6_dm_reg;
    logic [1:0]             sgn_reg [6:ST_SAT-1];
    logic                   deg_reg [3:ST_OUT-1];
    logic signed [CW-1:0]   cen_reg [ST_SAT:ST_OUT-1][2];
    logic signed [DW-1:0]   dif_reg [4];
    logic signed [D2W-1:0]  sq_reg  [4];
    logic [RW-1:0]          ra_reg;
    logic                   ins_reg [ST_SUM:ST_OUT-1];
    logic signed [CW-1:0]   out_cx_reg;
    logic signed [CW-1:0]   out_cy_reg;
    logic [CW-2:0]          out_r_reg;
    logic                   out_in_reg;
    logic                   out_deg_reg;

    logic signed [DW-1:0]   dy_next[3];
    logic signed [DW-1:0]   dx_next[3];
    logic [CW-1:0]          quo[2];
    logic                   ovf[2];
    logic signed [CW-1:0]   cen_next[2];
    logic [CW-2:0]          root;
    logic [RW-1:0]          rp_sum;

    assign en          = !v_reg[NS-1] || result.ready;
    assign query.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], query.valid};
        end
    end

    always_comb
    begin
        dy_next[0] = DW'(query.by_coord) - DW'(query.cy);
        dy_next[1] = DW'(query.cy) - DW'(query.ay);
        dy_next[2] = DW'(query.ay) - DW'(query.by_coord);
        dx_next[0] = DW'(query.cx) - DW'(query.bx);
        dx_next[1] = DW'(query.ax) - DW'(query.cx);
        dx_next[2] = DW'(query.bx) - DW'(query.ax);
    end

    // determinant, squared norms and center numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pts_reg[0] <= '{ax: query.ax, ay: query.ay, px: query.px, py: query.py};
            for (int k = 1; k <= ST_SAT; k++)
            begin
                pts_reg[k] <= pts_reg[k-1];
            end
            s0_x_reg[0] <= query.ax;
            s0_x_reg[1] <= query.bx;
            s0_x_reg[2] <= query.cx;
            s0_y_reg[0] <= query.ay;
            s0_y_reg[1] <= query.by_coord;
            s0_y_reg[2] <= query.cy;
            for (int i = 0; i < 3; i++)
            begin
                s0_dy_reg[i]   <= dy_next[i];
                s0_dx_reg[i]   <= dx_next[i];
                s1_detp_reg[i] <= PW'(s0_x_reg[i]) * PW'(s0_dy_reg[i]);
                s1_sqx_reg[i]  <= SQ2W'(s0_x_reg[i]) * SQ2W'(s0_x_reg[i]);
                s1_sqy_reg[i]  <= SQ2W'(s0_y_reg[i]) * SQ2W'(s0_y_reg[i]);
                s1_dy_reg[i]   <= s0_dy_reg[i];
                s1_dx_reg[i]   <= s0_dx_reg[i];
                s2_aa_reg[i]   <= $unsigned(s1_sqx_reg[i]) + $unsigned(s1_sqy_reg[i]);
                s2_dy_reg[i]   <= s1_dy_reg[i];
                s2_dx_reg[i]   <= s1_dx_reg[i];
                // split the norm into two halves to keep multipliers narrow
                s3_xlo_reg[i]  <= LPW'($signed({1'b0, s2_aa_reg[i][CW-1:0]}))
                                  * LPW'(s2_dy_reg[i]);
                s3_xhi_reg[i]  <= LPW'($signed({1'b0, s2_aa_reg[i][SQ2W-1:CW]}))
                                  * LPW'(s2_dy_reg[i]);
                s3_ylo_reg[i]  <= LPW'($signed({1'b0, s2_aa_reg[i][CW-1:0]}))
                                  * LPW'(s2_dx_reg[i]);
                s3_yhi_reg[i]  <= LPW'($signed({1'b0, s2_aa_reg[i][SQ2W-1:CW]}))
                                  * LPW'(s2_dx_reg[i]);
                s4_npx_reg[i]  <= (NPW'(s3_xhi_reg[i]) <<< CW) + NPW'(s3_xlo_reg[i]);
                s4_npy_reg[i]  <= (NPW'(s3_yhi_reg[i]) <<< CW) + NPW'(s3_ylo_reg[i]);
            end
            s2_det_reg <= DETW'(s1_detp_reg[0]) + DETW'(s1_detp_reg[1])
                          + DETW'(s1_detp_reg[2]);
            s3_den_reg <= DENW'(s2_det_reg) <<< 1;
            deg_reg[3] <= (s2_det_reg == '0);
            for (int k = 4; k < ST_OUT; k++)
            begin
                deg_reg[k] <= deg_reg[k-1];
            end
            s4_den_reg <= s3_den_reg;
            s5_den_reg <= s4_den_reg;
            s5_nx_reg  <= NW'(s4_npx_reg[0]) + NW'(s4_npx_reg[1]) + NW'(s4_npx_reg[2]);
            s5_ny_reg  <= NW'(s4_npy_reg[0]) + NW'(s4_npy_reg[1]) + NW'(s4_npy_reg[2]);
            s6_nxm_reg <= s5_nx_reg[NW-1] ? NW'(-s5_nx_reg) : NW'(s5_nx_reg);
            s6_nym_reg <= s5_ny_reg[NW-1] ? NW'(-s5_ny_reg) : NW'(s5_ny_reg);
            s6_dm_reg  <= s5_den_reg[DENW-1] ? DENW'(-s5_den_reg) : DENW'(s5_den_reg);
            sgn_reg[6] <= {s5_ny_reg[NW-1] ^ s5_den_reg[DENW-1],
                           s5_nx_reg[NW-1] ^ s5_den_reg[DENW-1]};
            for (int k = 7; k < ST_SAT; k++)
            begin
                sgn_reg[k] <= sgn_reg[k-1];
            end
        end
    end

    cct_divider #(.CW(CW)) u_div_x
    (
        .clk (clk),
        .en  (en),
        .num (s6_nxm_reg),
        .den (s6_dm_reg),
        .quo (quo[0]),
        .ovf (ovf[0])
    );

    cct_divider #(.CW(CW)) u_div_y
    (
        .clk (clk),
        .en  (en),
        .num (s6_nym_reg),
        .den (s6_dm_reg),
        .quo (quo[1]),
        .ovf (ovf[1])
    );

    // saturate the quotient magnitudes and restore sign; zero for collinear vertices
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (deg_reg[ST_SAT-1])
            begin
                cen_next[i] = '0;
            end
            else if (sgn_reg[ST_SAT-1][i])
            begin
                if (ovf[i] || (quo[i][CW-1] && (quo[i][CW-2:0] != '0)))
                    cen_next[i] = CMIN;
                else
                    cen_next[i] = -$signed(quo[i]);
            end
            else
            begin
                if (ovf[i] || quo[i][CW-1])
                    cen_next[i] = CMAX;
                else
                    cen_next[i] = $signed(quo[i]);
            end
        end
    end

    assign rp_sum = RW'($unsigned(sq_reg[2])) + RW'($unsigned(sq_reg[3]));

    // radius and membership
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cen_reg[ST_SAT] <= cen_next;
            for (int k = ST_SAT + 1; k < ST_OUT; k++)
            begin
                cen_reg[k] <= cen_reg[k-1];
            end
            dif_reg[0] <= DW'(pts_reg[ST_SAT].ax) - DW'(cen_reg[ST_SAT][0]);
            dif_reg[1] <= DW'(pts_reg[ST_SAT].ay) - DW'(cen_reg[ST_SAT][1]);
            dif_reg[2] <= DW'(pts_reg[ST_SAT].px) - DW'(cen_reg[ST_SAT][0]);
            dif_reg[3] <= DW'(pts_reg[ST_SAT].py) - DW'(cen_reg[ST_SAT][1]);
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= D2W'(dif_reg[i]) * D2W'(dif_reg[i]);
            end
            ra_reg <= RW'($unsigned(sq_reg[0])) + RW'($unsigned(sq_reg[1]));
            ins_reg[ST_SUM] <= (rp_sum <= (RW'($unsigned(sq_reg[0]))
                                           + RW'($unsigned(sq_reg[1]))));
            for (int k = ST_SUM + 1; k < ST_OUT; k++)
            begin
                ins_reg[k] <= ins_reg[k-1];
            end
            out_cx_reg  <= cen_reg[ST_OUT-1][0];
            out_cy_reg  <= cen_reg[ST_OUT-1][1];
            out_r_reg   <= deg_reg[ST_OUT-1] ? '0 : root;
            out_in_reg  <= ins_reg[ST_OUT-1] && !deg_reg[ST_OUT-1];
            out_deg_reg <= deg_reg[ST_OUT-1];
        end
    end

    cct_sqrt #(.CW(CW)) u_sqrt
    (
        .clk  (clk),
        .en   (en),
        .ra   (ra_reg),
        .root (root)
    );

    assign result.valid      = v_reg[NS-1];
    assign result.center_x   = out_cx_reg;
    assign result.center_y   = out_cy_reg;
    assign result.radius     = out_r_reg;
    assign result.inside_res = out_in_reg;
    assign result.degenerate = out_deg_reg;

    `CCT_ASSERT_NOW(a_degen_zero, result.valid && result.degenerate,
        result.radius == '0 && !result.inside_res && result.center_x == '0
        && result.center_y == '0, "degenerate result carries nonzero fields")
    `CCT_ASSERT_NOW(a_empty_ready, !result.valid, query.ready,
        "input stalled while output register is empty")
    `CCT_ASSERT_NEXT(a_advance, v_reg[0] && en, v_reg[1],
        "transaction lost between first pipeline stages")

endmodule

`default_nettype wire
